[hdl/assert_macros.svh]
// Assertion macros shared by the FFT block.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ASSERT_SAME(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define ASSERT_NEXT(label, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

[hdl/r2fft_pkg.sv]
// Package for the radix-2 FFT: types, the FSM state enum, sizes and helper functions.
// Holds the Q1.31 cosine table that the twiddle ROM is built from. No dependencies.
`timescale 1ns / 1ps
package r2fft_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = 6;
	localparam int SAMPLE_W    = 16;
	localparam int BIN_W       = 23;
	localparam int CNT_W       = 7;
	localparam int LVL_W       = 3;
	localparam int ENTRY_W     = 2 * BIN_W;
	localparam int BIN_MAX     = 4194303;
	localparam int BIN_MIN     = -4194304;

	// cos(pi m / 32) in Q1.31, m = 0..16
	localparam logic [31:0] COS_Q31 [17] = '{
		32'h80000000, 32'h7F62368F, 32'h7D8A5F40, 32'h7A7D055B, 32'h7641AF3D,
		32'h70E2CBC6, 32'h6A6D98A4, 32'h62F201AC, 32'h5A82799A, 32'h5133CC94,
		32'h471CECE7, 32'h3C56BA70, 32'h30FBC54D, 32'h25280C5E, 32'h18F8B83C,
		32'h0C8BD35E, 32'h00000000
	};

	typedef enum logic [2:0] {
		S_LOAD,
		S_PAD,
		S_BF_RD,
		S_BF_WAIT,
		S_BF_WO,
		S_EMIT,
		S_DRAIN
	} fsm_state_t;

	typedef struct packed {
		logic signed [BIN_W-1:0] re;
		logic signed [BIN_W-1:0] im;
	} cplx_t;

	// Control handed to the butterfly unit with each read issue
	typedef struct packed {
		logic       issue;
		logic       conj;
		logic [4:0] tw_idx;
	} bfly_ctrl_t;

	function automatic logic [ADDR_W-1:0] bitrev6(input logic [ADDR_W-1:0] a);
		logic [ADDR_W-1:0] r;
		for (int b = 0; b < ADDR_W; b++) begin
			r[ADDR_W-1-b] = a[b];
		end
		return r;
	endfunction

	function automatic logic signed [BIN_W-1:0] sat23(input logic signed [31:0] v);
		logic signed [BIN_W-1:0] r;
		if (v > BIN_MAX) begin
			r = BIN_W'(BIN_MAX);
		end else if (v < BIN_MIN) begin
			r = BIN_W'(BIN_MIN);
		end else begin
			r = v[BIN_W-1:0];
		end
		return r;
	endfunction

	// Q1.(tb-1) ROM word, rounded from the Q1.31 constant; indexes above 16 clamp
	function automatic logic [32:0] rom_word(input logic [4:0] m, input int tb);
		logic [4:0]  mc;
		logic [32:0] c;
		mc = (m > 5'd16) ? 5'd16 : m;
		c  = {1'b0, COS_Q31[mc]};
		return (c + (33'd1 << (31 - tb))) >> (32 - tb);
	endfunction

endpackage

[hdl/r2fft_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module r2fft_ram #(
	parameter int WIDTH = 46,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

[hdl/r2fft_bfly.sv]
// Pipelined radix-2 butterfly: twiddle ROM, complex multiply, rounding, add/sub.
// Depends on r2fft_pkg. Result is valid once the read issue has passed registered stages s0 to s3.
`timescale 1ns / 1ps
module r2fft_bfly #(
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  r2fft_pkg::bfly_ctrl_t ctrl,
	input  r2fft_pkg::cplx_t    even_in,
	input  r2fft_pkg::cplx_t    odd_in,
	output logic                res_valid,
	output r2fft_pkg::cplx_t    even_out,
	output r2fft_pkg::cplx_t    odd_out
);
	import r2fft_pkg::*;

	localparam int TW = TWIDDLE_BITS + 1;
	localparam int PW = BIN_W + TW;
	localparam int SW = PW + 1;
	localparam int RW = SW - (TWIDDLE_BITS - 1);

	logic [32:0]            rom_a, rom_b;
	logic signed [TW-1:0]   wr_c, wi_c;
	logic signed [TW-1:0]   w_re_s0, w_im_s0;
	logic                   conj_s0, v_s0;
	logic signed [BIN_W-1:0] o_im_c, e_im_c;
	logic signed [PW-1:0]   p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [BIN_W-1:0] e_re_s1, e_im_s1;
	logic                   v_s1;
	logic signed [SW-1:0]   sum_r, sum_i;
	logic signed [RW-1:0]   tr_s2, ti_s2;
	logic signed [BIN_W-1:0] e_re_s2, e_im_s2;
	logic                   v_s2;
	logic                   v_s3;

	// twiddle e^(-2 pi i m / 64) from the quarter-wave table
	always_comb begin
		if (ctrl.tw_idx <= 5'd16) begin
			rom_a = rom_word(ctrl.tw_idx, TWIDDLE_BITS);
			rom_b = rom_word(5'd16 - ctrl.tw_idx, TWIDDLE_BITS);
			wr_c  = signed'(rom_a[TW-1:0]);
			wi_c  = -signed'(rom_b[TW-1:0]);
		end else begin
			rom_a = rom_word(5'(6'd32 - {1'b0, ctrl.tw_idx}), TWIDDLE_BITS);
			rom_b = rom_word(ctrl.tw_idx - 5'd16, TWIDDLE_BITS);
			wr_c  = -signed'(rom_a[TW-1:0]);
			wi_c  = -signed'(rom_b[TW-1:0]);
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s0 <= ctrl.issue;
			v_s1 <= v_s0;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// s0: twiddle registered alongside the memory read
	always_ff @(posedge clk) begin
		if (ctrl.issue) begin
			w_re_s0 <= wr_c;
			w_im_s0 <= wi_c;
			conj_s0 <= ctrl.conj;
		end
	end

	// input conjugation on the first stage of an inverse transform
	assign o_im_c = conj_s0 ? -odd_in.im : odd_in.im;
	assign e_im_c = conj_s0 ? -even_in.im : even_in.im;

	// s1: four partial products
	always_ff @(posedge clk) begin
		if (v_s0) begin
			p_rr_s1 <= odd_in.re * w_re_s0;
			p_ii_s1 <= o_im_c * w_im_s0;
			p_ri_s1 <= odd_in.re * w_im_s0;
			p_ir_s1 <= o_im_c * w_re_s0;
			e_re_s1 <= even_in.re;
			e_im_s1 <= e_im_c;
		end
	end

	// s2: combine and round to nearest
	assign sum_r = SW'(p_rr_s1) - SW'(p_ii_s1) + (SW'(1) <<< (TWIDDLE_BITS - 2));
	assign sum_i = SW'(p_ri_s1) + SW'(p_ir_s1) + (SW'(1) <<< (TWIDDLE_BITS - 2));

	always_ff @(posedge clk) begin
		if (v_s1) begin
			tr_s2   <= RW'(sum_r >>> (TWIDDLE_BITS - 1));
			ti_s2   <= RW'(sum_i >>> (TWIDDLE_BITS - 1));
			e_re_s2 <= e_re_s1;
			e_im_s2 <= e_im_s1;
		end
	end

	// s3: saturated sum and difference
	always_ff @(posedge clk) begin
		if (v_s2) begin
			even_out.re <= sat23(32'(e_re_s2) + 32'(tr_s2));
			even_out.im <= sat23(32'(e_im_s2) + 32'(ti_s2));
			odd_out.re  <= sat23(32'(e_re_s2) - 32'(tr_s2));
			odd_out.im  <= sat23(32'(e_im_s2) - 32'(ti_s2));
		end
	end

	assign res_valid = v_s3;

endmodule

[hdl/radix2_complex_fft.sv]
// Radix-2 FFT top: load into bit-reversed RAM slots, pad, butterflies, emit natural order.
// Load: one sample per cycle while start is high. After last_sample: pad (zeros written to
// unused slots up to N), then (N/2)*log2(N) butterflies (read, four-stage butterfly unit,
// two writes on the single write port), then N bins on consecutive cycles, each passing the
// RAM read and output register. Results carry a one-cycle strobe and cannot be stalled.
// Async reset clears the counters, the mode register and the FSM; RAM is not cleared.
// Depends on r2fft_pkg, r2fft_ram, r2fft_bfly and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module radix2_complex_fft #(
	parameter int MAX_POINTS   = 64,
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_wdata,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_re,
	input  logic signed [r2fft_pkg::SAMPLE_W-1:0] sample_im,
	input  logic                                  last_sample,
	output logic                                  valid,
	output logic signed [r2fft_pkg::BIN_W-1:0]    bin_re,
	output logic signed [r2fft_pkg::BIN_W-1:0]    bin_im,
	output logic                                  last_bin,
	output logic                                  overflow
);
	import r2fft_pkg::*;

	fsm_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_new, pad_q, n_q, n_c;
	logic [LVL_W-1:0]  lvl_q, lvl_c, st_q, shift_c;
	logic [4:0]        j_q;
	logic [ADDR_W-1:0] oidx_q;
	logic              ovf_seen_q, inv_cfg_q, inv_q, ovf_q;
	logic              accept, store_ok;
	logic              pad_done, j_last, st_last, o_last;

	logic [ADDR_W-1:0] jx, mask, e_idx, o_idx, e_addr, o_addr, out_addr;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr_a;
	cplx_t             ram_wdata, rdata_a, rdata_b;

	bfly_ctrl_t        bf_ctrl;
	logic              res_valid;
	cplx_t             even_out, odd_out;

	logic              rd_v_s1, rd_last_s1;
	logic signed [24:0] vr, vi, rr, ri;

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_cfg_q <= 1'b0;
		end else if (cfg_we) begin
			inv_cfg_q <= cfg_wdata;
		end
	end

	// load side: count and padded size after this transfer
	assign accept   = start && !busy;
	assign store_ok = cnt_q < CNT_W'(MAX_POINTS);
	assign cnt_new  = cnt_q + CNT_W'(store_ok);

	always_comb begin
		lvl_c = '0;
		for (int b = 0; b < ADDR_W; b++) begin
			if ((CNT_W'(1) << b) < cnt_new) begin
				lvl_c = LVL_W'(b + 1);
			end
		end
	end
	assign n_c = CNT_W'(1) << lvl_c;

	// butterfly addressing; slots sit at index << (6 - levels)
	assign shift_c  = LVL_W'(ADDR_W) - lvl_q;
	assign jx       = {1'b0, j_q};
	assign mask     = (ADDR_W'(1) << st_q) - ADDR_W'(1);
	assign e_idx    = ((jx & ~mask) << 1) | (jx & mask);
	assign o_idx    = e_idx | (ADDR_W'(1) << st_q);
	assign e_addr   = e_idx << shift_c;
	assign o_addr   = o_idx << shift_c;
	assign out_addr = oidx_q << shift_c;

	assign pad_done = pad_q == n_q;
	assign j_last   = CNT_W'(j_q) == (n_q >> 1) - CNT_W'(1);
	assign st_last  = st_q == lvl_q - LVL_W'(1);
	assign o_last   = CNT_W'(oidx_q) == n_q - CNT_W'(1);

	assign bf_ctrl.issue  = state_q == S_BF_RD;
	assign bf_ctrl.conj   = inv_q && (st_q == '0);
	assign bf_ctrl.tw_idx = 5'((jx & mask) << (LVL_W'(5) - st_q));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and RAM write/read port selection
	always_comb begin
		state_d     = state_q;
		ram_we      = 1'b0;
		ram_waddr   = bitrev6(cnt_q[ADDR_W-1:0]);
		ram_wdata.re = BIN_W'(sample_re);
		ram_wdata.im = BIN_W'(sample_im);
		ram_raddr_a = e_addr;
		unique case (state_q)
			S_LOAD: begin
				ram_we = accept && store_ok;
				if (accept && last_sample) begin
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				ram_waddr = bitrev6(pad_q[ADDR_W-1:0]);
				ram_wdata = '0;
				if (pad_done) begin
					state_d = (lvl_q == '0) ? S_EMIT : S_BF_RD;
				end else begin
					ram_we = 1'b1;
				end
			end
			S_BF_RD: begin
				state_d = S_BF_WAIT;
			end
			S_BF_WAIT: begin
				ram_waddr = e_addr;
				ram_wdata = even_out;
				if (res_valid) begin
					ram_we  = 1'b1;
					state_d = S_BF_WO;
				end
			end
			S_BF_WO: begin
				ram_we    = 1'b1;
				ram_waddr = o_addr;
				ram_wdata = odd_out;
				state_d   = (j_last && st_last) ? S_EMIT : S_BF_RD;
			end
			S_EMIT: begin
				ram_raddr_a = out_addr;
				if (o_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_LOAD;
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	assign busy = state_q != S_LOAD;

	// counters and per-vector settings
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			ovf_seen_q <= 1'b0;
			pad_q      <= '0;
			n_q        <= '0;
			lvl_q      <= '0;
			inv_q      <= 1'b0;
			ovf_q      <= 1'b0;
			st_q       <= '0;
			j_q        <= '0;
			oidx_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (last_sample) begin
							cnt_q      <= '0;
							ovf_seen_q <= 1'b0;
							pad_q      <= cnt_new;
							n_q        <= n_c;
							lvl_q      <= lvl_c;
							inv_q      <= inv_cfg_q;
							ovf_q      <= ovf_seen_q || !store_ok;
						end else begin
							cnt_q <= cnt_new;
							if (!store_ok) begin
								ovf_seen_q <= 1'b1;
							end
						end
					end
				end
				S_PAD: begin
					if (pad_done) begin
						st_q   <= '0;
						j_q    <= '0;
						oidx_q <= '0;
					end else begin
						pad_q <= pad_q + CNT_W'(1);
					end
				end
				S_BF_WO: begin
					if (j_last) begin
						j_q  <= '0;
						st_q <= st_q + LVL_W'(1);
					end else begin
						j_q <= j_q + 5'd1;
					end
				end
				S_EMIT: begin
					oidx_q <= oidx_q + ADDR_W'(1);
				end
				S_BF_RD, S_BF_WAIT, S_DRAIN: begin
				end
				default: begin
				end
			endcase
		end
	end

	r2fft_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.raddr_a(ram_raddr_a),
		.rdata_a(rdata_a),
		.raddr_b(o_addr),
		.rdata_b(rdata_b)
	);

	r2fft_bfly #(
		.TWIDDLE_BITS(TWIDDLE_BITS)
	) u_bfly (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (bf_ctrl),
		.even_in  (rdata_a),
		.odd_in   (rdata_b),
		.res_valid(res_valid),
		.even_out (even_out),
		.odd_out  (odd_out)
	);

	// emit pipeline: read tag, then output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
			valid      <= 1'b0;
			last_bin   <= 1'b0;
		end else begin
			rd_v_s1    <= state_q == S_EMIT;
			rd_last_s1 <= (state_q == S_EMIT) && o_last;
			valid      <= rd_v_s1;
			last_bin   <= rd_last_s1;
		end
	end

	// inverse: output conjugation, then rounding shift by log2(N)
	// with a single point there is no butterfly to conjugate the input, so output conjugation is skipped too
	assign vr = 25'(rdata_a.re);
	assign vi = (inv_q && (lvl_q != '0)) ? -25'(rdata_a.im) : 25'(rdata_a.im);
	always_comb begin
		if (inv_q && (lvl_q != '0)) begin
			rr = (vr + (25'sd1 <<< (lvl_q - LVL_W'(1)))) >>> lvl_q;
			ri = (vi + (25'sd1 <<< (lvl_q - LVL_W'(1)))) >>> lvl_q;
		end else begin
			rr = vr;
			ri = vi;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			bin_re   <= sat23(32'(rr));
			bin_im   <= sat23(32'(ri));
			overflow <= ovf_q;
		end
	end

	`ASSERT_NEXT(a_last_starts, accept && last_sample, busy, "last sample did not start transform")
	`ASSERT_NEXT(a_last_ends, valid && last_bin, !valid, "bin strobe after last bin")
	`ASSERT_SAME(a_bfly_wait, res_valid, state_q == S_BF_WAIT, "butterfly result out of step")

endmodule
